[rtl/core/tga_pkg.sv]
// ----------------------------------------------------------------------------
// TGA decoder package
// Shared types and constants for the truecolor TGA stream decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PACKET,
      PH_PIXEL,
      PH_SKIP
   } phase_type;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_BAD_TYPE  = 2'd0;
   localparam logic [1:0] ERR_ZERO_SIZE = 2'd1;
   localparam logic [1:0] ERR_BAD_DEPTH = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED = 2'd3;

   localparam logic [4:0] HDR_TYPE     = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH    = 5'd16;
   localparam logic [4:0] HDR_LAST     = 5'd17;

   localparam logic [7:0] TYPE_RAW  = 8'h02;
   localparam logic [7:0] TYPE_RLE  = 8'h0A;
   localparam logic [7:0] DEPTH_24  = 8'd24;
   localparam logic [7:0] DEPTH_32  = 8'd32;
   localparam int         RUN_FLAG_BIT = 7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] width;
      logic [15:0] height;
      logic        has_alpha;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_res;
      logic [1:0]  error_code;
      logic        image_done;
   } result_type;

endpackage

[rtl/core/tga_in_reg.sv]
// ----------------------------------------------------------------------------
// TGA input register
// Holds one accepted file byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module tga_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tga_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output tga_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   tga_pkg::item_type item_ff;
   logic              take;

   assign req_stall  = valid_ff && !advance;
   assign take       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      priority if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

[rtl/core/tga_decode.sv]
// ----------------------------------------------------------------------------
// TGA decode stage
// Header parsing, packet and pixel assembly state, and result formation for
// one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module tga_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  tga_pkg::item_type   item,
   output logic                produces,
   output tga_pkg::result_type result
);

   tga_pkg::phase_type phase_ff, phase_in, phase_step;
   logic [4:0]  header_count_ff, header_count_in;
   logic        run_coded_ff, run_coded_in;
   logic [15:0] image_width_ff, image_width_in;
   logic [15:0] image_height_ff, image_height_in;
   logic        four_byte_pixels_ff, four_byte_pixels_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [23:0] byte_hold_ff, byte_hold_in;

   logic [7:0]  b;
   logic        eof;
   logic        type_ok;
   logic        size_zero;
   logic        depth_bad;
   logic        header_ok;
   logic [1:0]  last_index;
   logic        pixel_emit;
   logic [31:0] rep_raw;
   logic [31:0] rep;
   logic [31:0] pixels_after;
   logic [7:0]  packet_after;
   logic [7:0]  packet_count_raw;
   logic [7:0]  packet_count;

   assign b          = item.data_byte;
   assign eof        = item.end_of_file;
   assign type_ok    = (b == tga_pkg::TYPE_RLE) || (b == tga_pkg::TYPE_RAW);
   assign size_zero  = (image_width_ff == 16'd0) || (image_height_ff == 16'd0);
   assign depth_bad  = (byte_hold_ff[7:0] != tga_pkg::DEPTH_24 &&
                        byte_hold_ff[7:0] != tga_pkg::DEPTH_32) ||
                       (byte_hold_ff[23:8] != 16'd0);
   assign header_ok  = !size_zero && !depth_bad;
   assign last_index = four_byte_pixels_ff ? 2'd3 : 2'd2;
   assign pixel_emit = byte_index_ff >= last_index;
   assign rep_raw    = (run_coded_ff && packet_is_run_ff) ? {24'd0, packet_left_ff} : 32'd1;
   assign rep        = (rep_raw > pixels_left_ff) ? pixels_left_ff : rep_raw;
   assign pixels_after = pixels_left_ff - rep;
   assign packet_after = packet_left_ff - rep[7:0];
   assign packet_count_raw = {1'b0, b[6:0]} + 8'd1;
   assign packet_count = ({24'd0, packet_count_raw} > pixels_left_ff) ?
                         pixels_left_ff[7:0] : packet_count_raw;

   // Next phase.
   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         tga_pkg::PH_HEADER: begin
            priority if (header_count_ff == tga_pkg::HDR_TYPE && !type_ok) begin
               phase_step = tga_pkg::PH_SKIP;
            end else if (header_count_ff >= tga_pkg::HDR_LAST) begin
               priority if (!header_ok) begin
                  phase_step = tga_pkg::PH_SKIP;
               end else if (run_coded_ff) begin
                  phase_step = tga_pkg::PH_PACKET;
               end else begin
                  phase_step = tga_pkg::PH_PIXEL;
               end
            end else begin
               phase_step = tga_pkg::PH_HEADER;
            end
         end
         tga_pkg::PH_PACKET: begin
            phase_step = tga_pkg::PH_PIXEL;
         end
         tga_pkg::PH_PIXEL: begin
            priority if (!pixel_emit) begin
               phase_step = tga_pkg::PH_PIXEL;
            end else if (pixels_after == 32'd0) begin
               phase_step = tga_pkg::PH_SKIP;
            end else if (run_coded_ff && packet_after == 8'd0) begin
               phase_step = tga_pkg::PH_PACKET;
            end else begin
               phase_step = tga_pkg::PH_PIXEL;
            end
         end
         tga_pkg::PH_SKIP: begin
            phase_step = tga_pkg::PH_SKIP;
         end
         default: begin
            phase_step = tga_pkg::PH_SKIP;
         end
      endcase
      phase_in = eof ? tga_pkg::PH_HEADER : phase_step;
   end

   // Datapath updates and result.
   always_comb begin
      header_count_in     = header_count_ff;
      run_coded_in        = run_coded_ff;
      image_width_in      = image_width_ff;
      image_height_in     = image_height_ff;
      four_byte_pixels_in = four_byte_pixels_ff;
      pixels_left_in      = pixels_left_ff;
      packet_left_in      = packet_left_ff;
      packet_is_run_in    = packet_is_run_ff;
      byte_index_in       = byte_index_ff;
      byte_hold_in        = byte_hold_ff;
      result              = '0;
      produces            = 1'b0;

      unique case (phase_ff)
         tga_pkg::PH_HEADER: begin
            if (header_count_ff < tga_pkg::HDR_LAST) begin
               header_count_in = header_count_ff + 5'd1;
            end
            priority if (header_count_ff == tga_pkg::HDR_TYPE) begin
               if (type_ok) begin
                  run_coded_in = (b == tga_pkg::TYPE_RLE);
               end else begin
                  result.kind       = tga_pkg::KIND_ERROR;
                  result.error_code = tga_pkg::ERR_BAD_TYPE;
                  produces          = 1'b1;
               end
            end else if (header_count_ff == tga_pkg::HDR_WIDTH_LO) begin
               image_width_in[7:0] = b;
            end else if (header_count_ff == tga_pkg::HDR_WIDTH_HI) begin
               image_width_in[15:8] = b;
            end else if (header_count_ff == tga_pkg::HDR_HEIGHT_LO) begin
               image_height_in[7:0] = b;
            end else if (header_count_ff == tga_pkg::HDR_HEIGHT_HI) begin
               image_height_in[15:8] = b;
            end else if (header_count_ff == tga_pkg::HDR_DEPTH) begin
               byte_hold_in = {16'd0, b};
            end else if (header_count_ff >= tga_pkg::HDR_LAST) begin
               produces = 1'b1;
               priority if (size_zero) begin
                  result.kind       = tga_pkg::KIND_ERROR;
                  result.error_code = tga_pkg::ERR_ZERO_SIZE;
               end else if (depth_bad) begin
                  result.kind       = tga_pkg::KIND_ERROR;
                  result.error_code = tga_pkg::ERR_BAD_DEPTH;
               end else begin
                  four_byte_pixels_in = (byte_hold_ff[7:0] == tga_pkg::DEPTH_32);
                  result.kind         = tga_pkg::KIND_HEADER;
                  result.width        = image_width_ff;
                  result.height       = image_height_ff;
                  result.has_alpha    = four_byte_pixels_in;
                  pixels_left_in      = {16'd0, image_width_ff} *
                                        {16'd0, image_height_ff};
                  byte_index_in       = 2'd0;
                  byte_hold_in        = 24'd0;
                  packet_left_in      = 8'd0;
                  packet_is_run_in    = 1'b0;
               end
            end else begin
               header_count_in = header_count_ff + 5'd1;
            end
         end
         tga_pkg::PH_PACKET: begin
            packet_left_in   = packet_count;
            packet_is_run_in = b[tga_pkg::RUN_FLAG_BIT];
            byte_index_in    = 2'd0;
         end
         tga_pkg::PH_PIXEL: begin
            if (!pixel_emit) begin
               unique case (byte_index_ff)
                  2'd0:    byte_hold_in = {16'd0, b};
                  2'd1:    byte_hold_in = byte_hold_ff | {8'd0, b, 8'd0};
                  default: byte_hold_in = byte_hold_ff | {b, 16'd0};
               endcase
               byte_index_in = byte_index_ff + 2'd1;
            end else begin
               result.kind       = tga_pkg::KIND_RUN;
               result.has_alpha  = four_byte_pixels_ff;
               result.blue       = byte_hold_ff[7:0];
               result.green      = byte_hold_ff[15:8];
               result.red        = four_byte_pixels_ff ? byte_hold_ff[23:16] : b;
               result.alpha      = four_byte_pixels_ff ? b : 8'd0;
               result.repeat_res = rep[7:0];
               result.image_done = (pixels_after == 32'd0);
               pixels_left_in    = pixels_after;
               if (run_coded_ff) begin
                  packet_left_in = packet_after;
               end
               byte_index_in = 2'd0;
               produces      = 1'b1;
            end
         end
         tga_pkg::PH_SKIP: begin
            produces = 1'b0;
         end
         default: begin
            produces = 1'b0;
         end
      endcase

      if (eof) begin
         if (phase_step != tga_pkg::PH_SKIP) begin
            result            = '0;
            result.kind       = tga_pkg::KIND_ERROR;
            result.error_code = tga_pkg::ERR_TRUNCATED;
            produces          = 1'b1;
         end
         header_count_in     = 5'd0;
         run_coded_in        = 1'b0;
         image_width_in      = 16'd0;
         image_height_in     = 16'd0;
         four_byte_pixels_in = 1'b0;
         pixels_left_in      = 32'd0;
         packet_left_in      = 8'd0;
         packet_is_run_in    = 1'b0;
         byte_index_in       = 2'd0;
         byte_hold_in        = 24'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= tga_pkg::PH_HEADER;
         header_count_ff     <= 5'd0;
         run_coded_ff        <= 1'b0;
         image_width_ff      <= 16'd0;
         image_height_ff     <= 16'd0;
         four_byte_pixels_ff <= 1'b0;
         pixels_left_ff      <= 32'd0;
         packet_left_ff      <= 8'd0;
         packet_is_run_ff    <= 1'b0;
         byte_index_ff       <= 2'd0;
         byte_hold_ff        <= 24'd0;
      end else if (fire) begin
         phase_ff            <= phase_in;
         header_count_ff     <= header_count_in;
         run_coded_ff        <= run_coded_in;
         image_width_ff      <= image_width_in;
         image_height_ff     <= image_height_in;
         four_byte_pixels_ff <= four_byte_pixels_in;
         pixels_left_ff      <= pixels_left_in;
         packet_left_ff      <= packet_left_in;
         packet_is_run_ff    <= packet_is_run_in;
         byte_index_ff       <= byte_index_in;
         byte_hold_ff        <= byte_hold_in;
      end
   end

endmodule

[rtl/core/tga_out_reg.sv]
// ----------------------------------------------------------------------------
// TGA result register
// Holds one result item until the receiving side takes it.
// ----------------------------------------------------------------------------
module tga_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tga_pkg::result_type result,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tga_pkg::result_type rsp_result
);

   logic                valid_ff;
   logic                valid_in;
   tga_pkg::result_type result_ff;

   assign out_free   = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

[rtl/core/tga_rle_image_decoder_top.sv]
// ----------------------------------------------------------------------------
// TGA RLE image decoder
// Streaming decoder for uncompressed and run-length coded truecolor TGA files.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per clock cycle unless stalled. An item is
// registered in the input register on acceptance and decoded from that register
// by the header and pixel state logic; its result, if any, is loaded into the
// result register when the item advances, so a result passes the input register
// and then the result register before it is shown.
// Input items are stalled only while a byte that produces a result waits for
// a full result register whose item has not been taken.
module tga_rle_image_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_width,
   output logic [15:0] rsp_height,
   output logic        rsp_has_alpha,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_res,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_image_done
);

   tga_pkg::item_type   req_item;
   tga_pkg::item_type   item;
   tga_pkg::result_type result;
   tga_pkg::result_type rsp_result;
   logic                item_valid;
   logic                produces;
   logic                out_free;
   logic                advance;

   assign req_item.data_byte   = req_data_byte;
   assign req_item.end_of_file = req_end_of_file;
   assign advance = item_valid && (!produces || out_free);

   tga_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tga_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (item),
      .produces (produces),
      .result   (result)
   );

   tga_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && produces),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_kind       = rsp_result.kind;
   assign rsp_width      = rsp_result.width;
   assign rsp_height     = rsp_result.height;
   assign rsp_has_alpha  = rsp_result.has_alpha;
   assign rsp_red        = rsp_result.red;
   assign rsp_green      = rsp_result.green;
   assign rsp_blue       = rsp_result.blue;
   assign rsp_alpha      = rsp_result.alpha;
   assign rsp_repeat_res = rsp_result.repeat_res;
   assign rsp_error_code = rsp_result.error_code;
   assign rsp_image_done = rsp_result.image_done;

endmodule

[rtl/core/tga_checker.sv]
// ----------------------------------------------------------------------------
// TGA decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tga_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_width,
   input logic [15:0] rsp_height,
   input logic        rsp_has_alpha,
   input logic [7:0]  rsp_repeat_res,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_image_done
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_repeat_res) && $stable(rsp_error_code))
      else $error("stalled result item changed");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == tga_pkg::KIND_RUN |->
      rsp_repeat_res != 8'd0 && rsp_repeat_res <= 8'd128)
      else $error("pixel run with bad repeat count");

   a_header_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == tga_pkg::KIND_HEADER |->
      rsp_width != 16'd0 && rsp_height != 16'd0)
      else $error("header item with zero size");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == tga_pkg::KIND_ERROR |->
      !rsp_image_done && rsp_repeat_res == 8'd0 && !rsp_has_alpha)
      else $error("error item carries pixel data");

endmodule

bind tga_rle_image_decoder_top tga_checker u_checker (.*);
